// File: src/go_to_goal_velocity_controller_top_assert.svh
// Assertion macros used by the controller's checker file.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_TOP_ASSERT_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is high
`define GGVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define GGVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ggvc_pkg.sv
// Package: widths, constants, types and the arctangent table of the controller.
package ggvc_pkg;

  // Number formats
  localparam int FRAC_BITS     = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 8;

  // Field widths
  localparam int POS_W  = 16;
  localparam int HD_W   = 15;
  localparam int SPD_W  = 16;
  localparam int TURN_W = 15;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 8;

  // Stream packing
  localparam int IN_DATA_W  = ((2 * POS_W + HD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SPD_W + TURN_W + 7) / 8) * 8;

  // CORDIC datapath: offset is POS_W+1 signed, guard bits, plus gain headroom
  localparam int XY_W     = POS_W + 1 + GUARD_BITS + 3;
  localparam int Z_W      = 34;
  localparam int STAGE_W  = 5;
  localparam logic [Z_W-1:0] PI_Q30 = Z_W'(64'd3373259426);

  // Gain correction 1/K in Q24
  localparam int INVK_W = 24;
  localparam logic [INVK_W-1:0] INVK_Q24 = INVK_W'(10188014);
  localparam int PROD_W = (XY_W - 1) + INVK_W;
  localparam int DIST_SHIFT = 24 + GUARD_BITS;
  localparam int DIST_W = PROD_W - DIST_SHIFT;

  // Bearing and error
  localparam int BEAR_SHIFT = 30 - FRAC_BITS;
  localparam int BEAR_W     = Z_W - BEAR_SHIFT;
  localparam int ERR_W      = BEAR_W + 1;
  localparam int TURN_MAX   = (1 << TURN_W) - 1;

  // Thresholds 0.1 and 0.2, rounded
  localparam int NEAR_THR = ((1 << FRAC_BITS) + 5) / 10;
  localparam int TURN_THR = ((2 << FRAC_BITS) + 5) / 10;

  // Speed product
  localparam int SPROD_W = CFG_W + DIST_W;
  localparam int SPEED_W = SPROD_W - FRAC_BITS;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_X    = 8'd0,
    REG_TARGET_Y    = 8'd1,
    REG_GAIN        = 8'd2,
    REG_SPEED_LIMIT = 8'd3
  } ggvc_reg_t;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

  // Vector and angle carried along the cell chain
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [HD_W-1:0] hd;
  } ggvc_rot_t;

  // atan(2^-i) in Q30
  function automatic logic [Z_W-1:0] atan_q30(input logic [STAGE_W-1:0] i);
    logic [Z_W-1:0] a;
    case (i)
      5'd0:  a = 34'd843314857;
      5'd1:  a = 34'd497837829;
      5'd2:  a = 34'd263043837;
      5'd3:  a = 34'd133525159;
      5'd4:  a = 34'd67021687;
      5'd5:  a = 34'd33543516;
      5'd6:  a = 34'd16775851;
      5'd7:  a = 34'd8388437;
      5'd8:  a = 34'd4194283;
      5'd9:  a = 34'd2097149;
      5'd10: a = 34'd1048575;
      5'd11: a = 34'd524288;
      5'd12: a = 34'd262144;
      5'd13: a = 34'd131072;
      5'd14: a = 34'd65536;
      5'd15: a = 34'd32768;
      5'd16: a = 34'd16384;
      5'd17: a = 34'd8192;
      5'd18: a = 34'd4096;
      5'd19: a = 34'd2048;
      5'd20: a = 34'd1024;
      5'd21: a = 34'd512;
      5'd22: a = 34'd256;
      5'd23: a = 34'd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: src/ggvc_pre.sv
// Entry stage: goal offset with guard bits and the half-plane pre-rotation.
module ggvc_pre (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [ggvc_pkg::POS_W-1:0]            pos_x,
  input  logic [ggvc_pkg::POS_W-1:0]            pos_y,
  input  logic signed [ggvc_pkg::HD_W-1:0]      heading,
  input  logic [ggvc_pkg::CFG_W-1:0]            goal_x,
  input  logic [ggvc_pkg::CFG_W-1:0]            goal_y,
  output logic                                  out_valid,
  output ggvc_pkg::ggvc_rot_t                   out_rot
);

  logic signed [ggvc_pkg::POS_W:0]   dx;
  logic signed [ggvc_pkg::POS_W:0]   dy;
  logic signed [ggvc_pkg::XY_W-1:0]  gx;
  logic signed [ggvc_pkg::XY_W-1:0]  gy;
  ggvc_pkg::ggvc_rot_t               rot_next;

  // Offsets, then fold the left half-plane over with a start angle of +/-pi
  always_comb begin
    dx = $signed({1'b0, goal_x}) - $signed({1'b0, pos_x});
    dy = $signed({1'b0, goal_y}) - $signed({1'b0, pos_y});
    gx = ggvc_pkg::XY_W'(dx) <<< ggvc_pkg::GUARD_BITS;
    gy = ggvc_pkg::XY_W'(dy) <<< ggvc_pkg::GUARD_BITS;
    rot_next.hd = heading;
    if (dx[ggvc_pkg::POS_W]) begin
      rot_next.x = -gx;
      rot_next.y = -gy;
      rot_next.z = dy[ggvc_pkg::POS_W] ? -$signed(ggvc_pkg::PI_Q30)
                                        : $signed(ggvc_pkg::PI_Q30);
    end else begin
      rot_next.x = gx;
      rot_next.y = gy;
      rot_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot <= rot_next;
    end
  end

endmodule

// File: src/ggvc_cell.sv
// One CORDIC vectoring micro-rotation, registered.
module ggvc_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [ggvc_pkg::STAGE_W-1:0]         stage,
  input  logic                                 in_valid,
  input  ggvc_pkg::ggvc_rot_t                  in_rot,
  output logic                                 out_valid,
  output ggvc_pkg::ggvc_rot_t                  out_rot
);

  logic signed [ggvc_pkg::XY_W-1:0] xs;
  logic signed [ggvc_pkg::XY_W-1:0] ys;
  logic signed [ggvc_pkg::Z_W-1:0]  ang;
  ggvc_pkg::ggvc_rot_t              rot_next;

  // Rotate towards y = 0; zero y counts as the upper half
  always_comb begin
    xs  = in_rot.x >>> stage;
    ys  = in_rot.y >>> stage;
    ang = $signed(ggvc_pkg::atan_q30(stage));
    rot_next.hd = in_rot.hd;
    if (!in_rot.y[ggvc_pkg::XY_W-1]) begin
      rot_next.x = in_rot.x + ys;
      rot_next.y = in_rot.y - xs;
      rot_next.z = in_rot.z + ang;
    end else begin
      rot_next.x = in_rot.x - ys;
      rot_next.y = in_rot.y + xs;
      rot_next.z = in_rot.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot <= rot_next;
    end
  end

endmodule

// File: src/ggvc_post.sv
// Exit stages: gain correction, bearing error, thresholds and speed command.
module ggvc_post (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  ggvc_pkg::ggvc_rot_t                  in_rot,
  input  logic [ggvc_pkg::CFG_W-1:0]           gain,
  input  logic [ggvc_pkg::CFG_W-1:0]           speed_limit,
  output logic                                 out_valid,
  output logic [ggvc_pkg::SPD_W-1:0]           out_speed,
  output logic [ggvc_pkg::TURN_W-1:0]          out_turn
);

  // First stage: scaled magnitude and absolute bearing error
  logic [ggvc_pkg::XY_W-2:0]          xmag;
  logic signed [ggvc_pkg::BEAR_W-1:0] bearing;
  logic signed [ggvc_pkg::ERR_W-1:0]  err;
  logic [ggvc_pkg::ERR_W-1:0]         err_abs;

  logic                               v1;
  logic [ggvc_pkg::PROD_W-1:0]        prod1;
  logic [ggvc_pkg::ERR_W-1:0]         err1;

  always_comb begin
    xmag    = in_rot.x[ggvc_pkg::XY_W-1] ? '0 : in_rot.x[ggvc_pkg::XY_W-2:0];
    bearing = ggvc_pkg::BEAR_W'(in_rot.z >>> ggvc_pkg::BEAR_SHIFT);
    err     = ggvc_pkg::ERR_W'(bearing) - ggvc_pkg::ERR_W'(in_rot.hd);
    err_abs = err[ggvc_pkg::ERR_W-1] ? ggvc_pkg::ERR_W'(-err) : ggvc_pkg::ERR_W'(err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= ggvc_pkg::PROD_W'(xmag) * ggvc_pkg::PROD_W'(ggvc_pkg::INVK_Q24);
      err1  <= err_abs;
    end
  end

  // Second stage: distance, decisions and gain product
  logic [ggvc_pkg::DIST_W-1:0]        goal_range;
  logic                               v2;
  logic                               far2;
  logic                               turning2;
  logic [ggvc_pkg::TURN_W-1:0]        turn2;
  logic [ggvc_pkg::SPROD_W-1:0]       sprod2;

  assign goal_range = prod1[ggvc_pkg::PROD_W-1:ggvc_pkg::DIST_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far2     <= goal_range > ggvc_pkg::DIST_W'(ggvc_pkg::NEAR_THR);
      turning2 <= err1 > ggvc_pkg::ERR_W'(ggvc_pkg::TURN_THR);
      turn2    <= (err1 > ggvc_pkg::ERR_W'(ggvc_pkg::TURN_MAX))
                  ? ggvc_pkg::TURN_W'(ggvc_pkg::TURN_MAX)
                  : err1[ggvc_pkg::TURN_W-1:0];
      sprod2   <= ggvc_pkg::SPROD_W'(gain) * ggvc_pkg::SPROD_W'(goal_range);
    end
  end

  // Command select: stop at the goal, turn in place, or drive forward
  logic [ggvc_pkg::SPEED_W-1:0] speed;

  always_comb begin
    speed = sprod2[ggvc_pkg::SPROD_W-1:ggvc_pkg::FRAC_BITS];
    if (speed > ggvc_pkg::SPEED_W'(speed_limit)) begin
      speed = ggvc_pkg::SPEED_W'(speed_limit);
    end
    out_valid = v2;
    out_speed = '0;
    out_turn  = '0;
    if (far2) begin
      if (turning2) begin
        out_turn = turn2;
      end else begin
        out_speed = speed[ggvc_pkg::SPD_W-1:0];
      end
    end
  end

endmodule

// File: src/go_to_goal_velocity_controller_top.sv
// Top level: go-to-goal velocity controller with a pipelined CORDIC cell chain.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | pose: pos_x, pos_y, heading
//  m_*     | out | m_tvalid / m_tready  | command: linear_speed, turn_rate
//  cfg_*   | in  | cfg_valid / cfg_ready| register index and 16-bit value
//
// One pose per cycle while s_tready is high; a pose passes the entry stage, one cell
// per micro-rotation, two exit stages and the output register.
// Reset clears the valid bits and loads 1.0 into all four registers.
// The chain advances as a whole; a two-entry output buffer keeps it moving
// while one result waits, so s_tready drops only when both entries hold results.
module go_to_goal_velocity_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  // pos_x [15:0], pos_y [31:16], heading [46:32], zero [47]
  input  logic [ggvc_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // linear_speed [15:0], turn_rate [30:16], zero [31]
  output logic [ggvc_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ggvc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ggvc_pkg::CFG_W-1:0]          cfg_data
);

  localparam int N = ggvc_pkg::CORDIC_STAGES;

  // Configuration registers
  logic [ggvc_pkg::CFG_W-1:0] goal_x;
  logic [ggvc_pkg::CFG_W-1:0] goal_y;
  logic [ggvc_pkg::CFG_W-1:0] gain;
  logic [ggvc_pkg::CFG_W-1:0] speed_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x      <= ggvc_pkg::CFG_RESET;
      goal_y      <= ggvc_pkg::CFG_RESET;
      gain        <= ggvc_pkg::CFG_RESET;
      speed_limit <= ggvc_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ggvc_pkg::REG_TARGET_X:    goal_x      <= cfg_data;
        ggvc_pkg::REG_TARGET_Y:    goal_y      <= cfg_data;
        ggvc_pkg::REG_GAIN:        gain        <= cfg_data;
        ggvc_pkg::REG_SPEED_LIMIT: speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain advance: held only while the spare output entry is occupied
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // Entry stage
  logic                 valid_q [N+1];
  ggvc_pkg::ggvc_rot_t  rot_q   [N+1];

  ggvc_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .pos_x     (s_tdata[ggvc_pkg::POS_W-1:0]),
    .pos_y     (s_tdata[2*ggvc_pkg::POS_W-1:ggvc_pkg::POS_W]),
    .heading   ($signed(s_tdata[2*ggvc_pkg::POS_W+ggvc_pkg::HD_W-1:2*ggvc_pkg::POS_W])),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .out_valid (valid_q[0]),
    .out_rot   (rot_q[0])
  );

  // Micro-rotation cells
  for (genvar gi = 0; gi < N; gi++) begin : g_cell
    ggvc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage     (ggvc_pkg::STAGE_W'(gi)),
      .in_valid  (valid_q[gi]),
      .in_rot    (rot_q[gi]),
      .out_valid (valid_q[gi+1]),
      .out_rot   (rot_q[gi+1])
    );
  end

  // Exit stages
  logic                         res_valid;
  logic [ggvc_pkg::SPD_W-1:0]   res_speed;
  logic [ggvc_pkg::TURN_W-1:0]  res_turn;

  ggvc_post u_post (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (valid_q[N]),
    .in_rot      (rot_q[N]),
    .gain        (gain),
    .speed_limit (speed_limit),
    .out_valid   (res_valid),
    .out_speed   (res_speed),
    .out_turn    (res_turn)
  );

  // Output register and spare entry
  logic [ggvc_pkg::OUT_DATA_W-1:0] res_data;
  logic [ggvc_pkg::OUT_DATA_W-1:0] skid_data;
  logic                            res_fire;

  assign res_data = ggvc_pkg::OUT_DATA_W'({res_turn, res_speed});
  assign res_fire = res_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      m_tdata <= skid_valid ? skid_data : res_data;
    end else if (res_fire) begin
      skid_data <= res_data;
    end
  end

endmodule

// File: src/ggvc_checker.sv
// Port-level checker for the controller, bound to the top level.
`include "go_to_goal_velocity_controller_top_assert.svh"

module ggvc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic [ggvc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready
);

  logic [ggvc_pkg::SPD_W-1:0]  speed;
  logic [ggvc_pkg::TURN_W-1:0] turn;

  assign speed = m_tdata[ggvc_pkg::SPD_W-1:0];
  assign turn  = m_tdata[ggvc_pkg::SPD_W+ggvc_pkg::TURN_W-1:ggvc_pkg::SPD_W];

  // Driving and turning are exclusive
  `GGVC_ASSERT(a_excl, m_tvalid |-> (speed == '0 || turn == '0), "speed and turn both set")

  // A turn command only appears above the turn threshold
  `GGVC_ASSERT(a_turn_thr, (m_tvalid && turn != '0) |-> (turn > ggvc_pkg::TURN_THR), "turn below threshold")

  // Nothing comes out in the cycle after reset is released
  `GGVC_ASSERT_ALWAYS(a_rst_quiet, ($past(rst) && !rst) |-> !m_tvalid, "output valid after reset")

  // A stalled result holds
  `GGVC_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled item changed")

  // Input only stalls while a result is waiting at the output
  `GGVC_ASSERT(a_stall_full, !s_tready |-> m_tvalid, "input stalled with empty output")

endmodule

bind go_to_goal_velocity_controller_top ggvc_checker u_ggvc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
